FILE: rtl/core/cshl_pkg.sv
// Shared types, character codes and keyword table for the C syntax highlight lexer.
package cshl_pkg;

    // Highlight classes as they appear on the result channel.
    typedef enum logic [2:0] {
        HL_NORMAL  = 3'd0,
        HL_COMMENT = 3'd1,
        HL_KEYWORD = 3'd2,
        HL_TYPE    = 3'd3,
        HL_STRING  = 3'd4,
        HL_NUMBER  = 3'd5
    } hl_class_t;

    // Kind of quote that opened the current string.
    typedef enum logic [1:0] {
        QK_NONE   = 2'd0,
        QK_DOUBLE = 2'd1,
        QK_SINGLE = 2'd2
    } quote_kind_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNTAX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRINGS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBERS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMENT = 2'd3;

    // Configuration bits as seen by the classifier.
    typedef struct packed {
        logic syntax_on;
        logic strings_on;
        logic numbers_on;
        logic comment_on;
    } cfg_t;

    // Status of the lookahead window towards the output side.
    typedef struct packed {
        logic can_emit;
        logic head_end;
        logic full;
    } win_status_t;

    // Character codes used by the rules.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Keyword table: text is left aligned, character 0 in the top byte.
    localparam int KW_MAX_LEN   = 8;
    localparam int KW_SLOTS     = 32;
    localparam int KEYWORD_COUNT = 23;
    localparam int KW_LEN_W     = 4;
    localparam int KW_LEFT_W    = 3;

    typedef struct packed {
        logic [KW_MAX_LEN-1:0][7:0] text;
        logic [KW_LEN_W-1:0]        len;
        logic                       is_type;
    } kw_entry_t;

    localparam kw_entry_t KW_TABLE [KW_SLOTS] = '{
        0:  '{{"switch",   16'h0}, 4'd6, 1'b0},
        1:  '{{"if",       48'h0}, 4'd2, 1'b0},
        2:  '{{"while",    24'h0}, 4'd5, 1'b0},
        3:  '{{"for",      40'h0}, 4'd3, 1'b0},
        4:  '{{"break",    24'h0}, 4'd5, 1'b0},
        5:  '{{"continue"},        4'd8, 1'b0},
        6:  '{{"return",   16'h0}, 4'd6, 1'b0},
        7:  '{{"else",     32'h0}, 4'd4, 1'b0},
        8:  '{{"struct",   16'h0}, 4'd6, 1'b0},
        9:  '{{"union",    24'h0}, 4'd5, 1'b0},
        10: '{{"typedef",   8'h0}, 4'd7, 1'b0},
        11: '{{"static",   16'h0}, 4'd6, 1'b0},
        12: '{{"enum",     32'h0}, 4'd4, 1'b0},
        13: '{{"class",    24'h0}, 4'd5, 1'b0},
        14: '{{"case",     32'h0}, 4'd4, 1'b0},
        15: '{{"int",      40'h0}, 4'd3, 1'b1},
        16: '{{"long",     32'h0}, 4'd4, 1'b1},
        17: '{{"double",   16'h0}, 4'd6, 1'b1},
        18: '{{"float",    24'h0}, 4'd5, 1'b1},
        19: '{{"char",     32'h0}, 4'd4, 1'b1},
        20: '{{"unsigned"},        4'd8, 1'b1},
        21: '{{"signed",   16'h0}, 4'd6, 1'b1},
        22: '{{"void",     32'h0}, 4'd4, 1'b1},
        default: '{64'h0, 4'd0, 1'b0}
    };

    // Separator test: NUL, blank, control whitespace and the punctuation set.
    function automatic logic is_sep(input logic [7:0] c);
        logic r;
        r = 1'b0;
        if (c == CH_NUL || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
        begin
            r = 1'b1;
        end
        case (c)
            8'h2C, 8'h2E, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2F, 8'h2A,
            8'h3D, 8'h7E, 8'h25, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h3B:
            begin
                r = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/cshl_window.sv
// Lookahead window: holds waiting bytes, masks bytes past the line end and decides when to emit.
module cshl_window #(
    parameter int LOOKAHEAD = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 ch,
    input  logic                       line_end,
    input  logic                       pop,
    output logic [LOOKAHEAD-1:0][7:0]  peek,
    output cshl_pkg::win_status_t      status
);

    localparam int CW = $clog2(LOOKAHEAD + 1);

    logic [LOOKAHEAD-1:0][7:0] data_reg;
    logic [LOOKAHEAD-1:0]      end_reg;
    logic [CW-1:0]             cnt_reg;
    logic [CW-1:0]             cnt_next;
    logic [CW-1:0]             widx;
    logic [LOOKAHEAD-1:0]      valid;
    logic [LOOKAHEAD-1:0]      beyond;
    logic                      any_end;

    // Occupancy and the slot that the incoming byte lands in after any shift.
    assign widx     = cnt_reg - CW'(pop);
    assign cnt_next = cnt_reg + CW'(accept) - CW'(pop);

    // Valid slots, and slots that lie past the first line end of the window.
    always_comb
    begin
        any_end = 1'b0;
        for (int k = 0; k < LOOKAHEAD; k++)
        begin
            valid[k] = CW'(k) < cnt_reg;
        end
        beyond[0] = 1'b0;
        for (int k = 1; k < LOOKAHEAD; k++)
        begin
            beyond[k] = beyond[k-1] | (valid[k-1] & end_reg[k-1]);
        end
        for (int k = 0; k < LOOKAHEAD; k++)
        begin
            any_end = any_end | (valid[k] & end_reg[k]);
            peek[k] = (valid[k] && !beyond[k]) ? data_reg[k] : cshl_pkg::CH_NUL;
        end
    end

    // The head may leave once its line has ended or the window is full of its line.
    always_comb
    begin
        status.full     = cnt_reg == CW'(LOOKAHEAD);
        status.can_emit = valid[0] && (any_end || status.full);
        status.head_end = valid[0] && end_reg[0];
    end

    // Byte storage: shift towards the head on a pop, write the new byte behind the last.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LOOKAHEAD; k++)
        begin
            if (accept && CW'(k) == widx)
            begin
                data_reg[k] <= ch;
                end_reg[k]  <= line_end;
            end
            else if (pop && k < LOOKAHEAD - 1)
            begin
                data_reg[k] <= data_reg[k+1];
                end_reg[k]  <= end_reg[k+1];
            end
        end
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(LOOKAHEAD))
        else $error("window fill count above depth");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !accept |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("window count did not drop after a pop");
`endif

endmodule

FILE: rtl/core/cshl_classify.sv
// Line lexer state and the classification of the byte at the head of the window.
module cshl_classify #(
    parameter int LOOKAHEAD = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cshl_pkg::cfg_t             cfg,
    input  logic [LOOKAHEAD-1:0][7:0]  peek,
    input  logic                       step,
    input  logic                       head_end,
    output cshl_pkg::hl_class_t        cls
);

    localparam int EXT = cshl_pkg::KW_MAX_LEN + 1;

    cshl_pkg::quote_kind_t quote_reg, quote_next;
    cshl_pkg::hl_class_t   last_class_reg;
    cshl_pkg::hl_class_t   cls_v;
    logic                  esc_reg, esc_next;
    logic                  after_sep_reg, after_sep_next;
    logic [cshl_pkg::KW_LEFT_W-1:0] kw_left_reg, kw_left_next;
    logic                  kw_type_reg, kw_type_next;
    logic                  in_comment_reg, in_comment_next;

    logic [EXT-1:0][7:0]   ext;
    logic                  kw_hit;
    logic [cshl_pkg::KW_LEN_W-1:0] kw_len;
    logic                  kw_is_type;
    logic [7:0]            c;
    logic                  digit;

    // Lookahead bytes widened to the longest keyword plus its separator; the rest read NUL.
    for (genvar j = 0; j < EXT; j++)
    begin : g_ext
        if (j < LOOKAHEAD)
        begin : g_in
            assign ext[j] = peek[j];
        end
        else
        begin : g_nul
            assign ext[j] = cshl_pkg::CH_NUL;
        end
    end

    assign c     = ext[0];
    assign digit = (c >= cshl_pkg::CH_ZERO) && (c <= cshl_pkg::CH_NINE);

    // Keyword compare against every table entry in parallel; the earliest entry wins.
    always_comb
    begin : kw_search
        logic eq;
        kw_hit     = 1'b0;
        kw_len     = '0;
        kw_is_type = 1'b0;
        for (int k = cshl_pkg::KEYWORD_COUNT - 1; k >= 0; k--)
        begin
            eq = (cshl_pkg::KW_TABLE[k].len != '0) &&
                 (int'(cshl_pkg::KW_TABLE[k].len) + 1 <= LOOKAHEAD);
            for (int j = 0; j < cshl_pkg::KW_MAX_LEN; j++)
            begin
                if (j < int'(cshl_pkg::KW_TABLE[k].len))
                begin
                    if (ext[j] != cshl_pkg::KW_TABLE[k].text[cshl_pkg::KW_MAX_LEN-1-j])
                    begin
                        eq = 1'b0;
                    end
                end
            end
            if (eq && cshl_pkg::is_sep(ext[cshl_pkg::KW_TABLE[k].len]))
            begin
                kw_hit     = 1'b1;
                kw_len     = cshl_pkg::KW_TABLE[k].len;
                kw_is_type = cshl_pkg::KW_TABLE[k].is_type;
            end
        end
    end

    // Rule priority: keyword tail, comment, comment start, string, number, keyword start.
    always_comb
    begin : rules
        logic done;
        quote_next      = quote_reg;
        esc_next        = esc_reg;
        after_sep_next  = after_sep_reg;
        kw_left_next    = kw_left_reg;
        kw_type_next    = kw_type_reg;
        in_comment_next = in_comment_reg;
        cls_v           = cshl_pkg::HL_NORMAL;
        done            = 1'b0;
        if (kw_left_reg != '0)
        begin
            kw_left_next = kw_left_reg - 1'b1;
            cls_v = kw_type_reg ? cshl_pkg::HL_TYPE : cshl_pkg::HL_KEYWORD;
        end
        else if (in_comment_reg)
        begin
            cls_v = cshl_pkg::HL_COMMENT;
        end
        else if (cfg.comment_on && !(cfg.strings_on && quote_reg != cshl_pkg::QK_NONE) &&
                 c == cshl_pkg::CH_SLASH && ext[1] == cshl_pkg::CH_SLASH)
        begin
            in_comment_next = 1'b1;
            cls_v = cshl_pkg::HL_COMMENT;
        end
        else
        begin
            if (cfg.strings_on)
            begin
                if (quote_reg != cshl_pkg::QK_NONE)
                begin
                    done  = 1'b1;
                    cls_v = cshl_pkg::HL_STRING;
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (c == cshl_pkg::CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        if ((quote_reg == cshl_pkg::QK_DOUBLE && c == cshl_pkg::CH_DQUOTE) ||
                            (quote_reg == cshl_pkg::QK_SINGLE && c == cshl_pkg::CH_SQUOTE))
                        begin
                            quote_next = cshl_pkg::QK_NONE;
                        end
                        after_sep_next = 1'b1;
                    end
                end
                else if (c == cshl_pkg::CH_DQUOTE || c == cshl_pkg::CH_SQUOTE)
                begin
                    done       = 1'b1;
                    cls_v      = cshl_pkg::HL_STRING;
                    quote_next = (c == cshl_pkg::CH_DQUOTE) ? cshl_pkg::QK_DOUBLE
                                                           : cshl_pkg::QK_SINGLE;
                end
            end
            if (!done && cfg.numbers_on &&
                ((digit && (after_sep_reg || last_class_reg == cshl_pkg::HL_NUMBER)) ||
                 (c == cshl_pkg::CH_DOT && last_class_reg == cshl_pkg::HL_NUMBER)))
            begin
                done           = 1'b1;
                after_sep_next = 1'b0;
                cls_v          = cshl_pkg::HL_NUMBER;
            end
            if (!done && after_sep_reg && kw_hit)
            begin
                done           = 1'b1;
                kw_type_next   = kw_is_type;
                kw_left_next   = cshl_pkg::KW_LEFT_W'(kw_len - 1'b1);
                after_sep_next = 1'b0;
                cls_v = kw_is_type ? cshl_pkg::HL_TYPE : cshl_pkg::HL_KEYWORD;
            end
            if (!done)
            begin
                after_sep_next = cshl_pkg::is_sep(c);
            end
        end
    end

    assign cls = cfg.syntax_on ? cls_v : cshl_pkg::HL_NORMAL;

    // Lexer state advances on each emitted byte while syntax_on is set and clears after the last byte of a line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg      <= cshl_pkg::QK_NONE;
            esc_reg        <= 1'b0;
            after_sep_reg  <= 1'b1;
            last_class_reg <= cshl_pkg::HL_NORMAL;
            kw_left_reg    <= '0;
            kw_type_reg    <= 1'b0;
            in_comment_reg <= 1'b0;
        end
        else if (step)
        begin
            if (head_end)
            begin
                quote_reg      <= cshl_pkg::QK_NONE;
                esc_reg        <= 1'b0;
                after_sep_reg  <= 1'b1;
                last_class_reg <= cshl_pkg::HL_NORMAL;
                kw_left_reg    <= '0;
                kw_type_reg    <= 1'b0;
                in_comment_reg <= 1'b0;
            end
            else if (cfg.syntax_on)
            begin
                quote_reg      <= quote_next;
                esc_reg        <= esc_next;
                after_sep_reg  <= after_sep_next;
                last_class_reg <= cls_v;
                kw_left_reg    <= kw_left_next;
                kw_type_reg    <= kw_type_next;
                in_comment_reg <= in_comment_next;
            end
        end
    end

`ifndef SYNTH
    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && head_end |=> (kw_left_reg == '0 && !in_comment_reg && !esc_reg &&
                              quote_reg == cshl_pkg::QK_NONE && after_sep_reg))
        else $error("line state not cleared after line end");

    a_kw_tail: assert property (@(posedge clk) disable iff (!rst_n)
        step && cfg.syntax_on && kw_left_reg != '0 |->
            (cls == cshl_pkg::HL_KEYWORD || cls == cshl_pkg::HL_TYPE))
        else $error("keyword tail byte not classed as keyword");

    a_comment_no_kw: assert property (@(posedge clk) disable iff (!rst_n)
        in_comment_reg |-> kw_left_reg == '0)
        else $error("keyword tail pending inside a comment");
`endif

endmodule

FILE: rtl/core/c_syntax_highlight_lexer_core.sv
// Top level of the C syntax highlight lexer: configuration registers, window, classifier, output register.
//
// Input channel (in_valid/in_stall, ch, line_end) takes one text byte per beat; line_end marks
// the last byte of a line. Output channel (out_valid/out_stall) gives one beat per byte, in input
// order: text_byte, its hl_class and line_done on the last byte of the line.
// A byte leaves once LOOKAHEAD bytes of its line are waiting or its line has ended, so a line of
// n bytes yields its first result in the output register after byte min(n, LOOKAHEAD) is taken,
// then one result per cycle while out_stall is low. The window keeps accepting bytes of the next
// line while the previous one drains, so with out_stall low input and output both sustain one
// beat per cycle; in_stall rises only when all LOOKAHEAD slots are occupied and the output
// register cannot take the head byte. Keyword matching compares the head of the window against the
// whole keyword table in parallel, combinationally between the window and output registers.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; write it
// only while no bytes are waiting. Reset empties the window, clears the line state and loads
// the register defaults (highlighting off, strings, numbers and comments enabled).
// While out_stall is high the output beat holds and the window keeps filling until full.
module c_syntax_highlight_lexer_core #(
    parameter int LOOKAHEAD = 9
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       ch,
    input  logic                             line_end,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       text_byte,
    output logic [2:0]                       hl_class,
    output logic                             line_done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cshl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                             cfg_data
);

    cshl_pkg::cfg_t              cfg_reg;
    cshl_pkg::win_status_t       win_st;
    cshl_pkg::hl_class_t         cls;
    cshl_pkg::hl_class_t         hl_class_reg;
    logic [LOOKAHEAD-1:0][7:0]   peek;
    logic                        accept;
    logic                        pop;
    logic                        out_ready;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  text_byte_reg;
    logic                        line_done_reg;

    // Handshake: the head leaves when the output register is free or being emptied.
    assign out_ready = !out_valid_reg || !out_stall;
    assign pop       = win_st.can_emit && out_ready;
    assign in_stall  = win_st.full && !pop;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.syntax_on  <= 1'b0;
            cfg_reg.strings_on <= 1'b1;
            cfg_reg.numbers_on <= 1'b1;
            cfg_reg.comment_on <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cshl_pkg::CFG_SYNTAX:  cfg_reg.syntax_on  <= cfg_data;
                cshl_pkg::CFG_STRINGS: cfg_reg.strings_on <= cfg_data;
                cshl_pkg::CFG_NUMBERS: cfg_reg.numbers_on <= cfg_data;
                cshl_pkg::CFG_COMMENT: cfg_reg.comment_on <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cshl_window #(
        .LOOKAHEAD (LOOKAHEAD)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ch       (ch),
        .line_end (line_end),
        .pop      (pop),
        .peek     (peek),
        .status   (win_st)
    );

    cshl_classify #(
        .LOOKAHEAD (LOOKAHEAD)
    ) u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .peek     (peek),
        .step     (pop),
        .head_end (win_st.head_end),
        .cls      (cls)
    );

    // Output register valid flag.
    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, loaded with the head byte and its class.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            text_byte_reg <= peek[0];
            hl_class_reg  <= cls;
            line_done_reg <= win_st.head_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_byte = text_byte_reg;
    assign hl_class  = hl_class_reg;
    assign line_done = line_done_reg;

endmodule
